// ===== hw/rtl/hlfd_pkg.sv =====
// Package with the constants, phase codes and result type of the header-length frame deframer.
package hlfd_pkg;

    localparam int MAX_POSITION = 128;
    localparam int POS_W        = $clog2(MAX_POSITION + 2);
    localparam int LEN_W        = 16;
    localparam int CMP_W        = LEN_W + 1;

    localparam logic [7:0] HDR_FIRST  = 8'hFA;
    localparam logic [7:0] HDR_SECOND = 8'hFB;

    localparam int LEN_DONE_POS  = 4;
    localparam int LEN_OVERHEAD  = 3;
    localparam int DATA_FIRST_POS = 5;
    localparam int SHORT_LEN     = 2;

    typedef enum logic [3:0] {
        PH_HUNT = 4'b0001,
        PH_CMD  = 4'b0010,
        PH_LEN  = 4'b0100,
        PH_DATA = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        ST_COMPLETE  = 2'd0,
        ST_TRUNCATED = 2'd1,
        ST_SHORT     = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] command;
        logic [7:0] data_byte;
        logic [6:0] byte_index;
        logic       is_checksum;
        logic       last;
        status_t    frame_status;
    } result_t;

endpackage

// ===== hw/rtl/hlfd_parser.sv =====
// Frame parser: header hunt, command and length capture, and per-byte result generation.
module hlfd_parser
    import hlfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    output logic       res_valid,
    output result_t    res
);

    phase_t                 phase_reg, phase_next;
    logic [7:0]             prev_byte_reg, prev_byte_next;
    logic [POS_W-1:0]       position_reg, position_next;
    logic [LEN_W-1:0]       frame_length_reg, frame_length_next;
    logic [7:0]             frame_command_reg, frame_command_next;

    logic [POS_W-1:0]       pos_inc;
    logic [CMP_W-1:0]       pos_ext;
    logic [CMP_W-1:0]       len_end;
    logic                   len_done;
    logic                   limit_hit;
    logic                   counted;
    logic                   frame_end;
    logic                   short_len;

    assign pos_inc   = position_reg + POS_W'(1);
    assign pos_ext   = CMP_W'(pos_inc);
    assign len_end   = CMP_W'(frame_length_reg) + CMP_W'(LEN_OVERHEAD);
    assign len_done  = pos_ext > len_end;
    assign limit_hit = pos_inc > POS_W'(MAX_POSITION);
    assign counted   = pos_ext <= (len_end + CMP_W'(1));
    assign frame_end = len_done || limit_hit;
    assign short_len = frame_length_reg < LEN_W'(SHORT_LEN);

    always_comb
    begin
        phase_next         = phase_reg;
        prev_byte_next     = rx_byte;
        position_next      = position_reg;
        frame_length_next  = frame_length_reg;
        frame_command_next = frame_command_reg;
        res_valid          = 1'b0;

        res.command      = frame_command_reg;
        res.data_byte    = rx_byte;
        res.byte_index   = 7'(pos_inc - POS_W'(DATA_FIRST_POS));
        res.is_checksum  = counted && (pos_ext >= len_end);
        res.last         = frame_end;
        res.frame_status = ST_COMPLETE;
        if (frame_end && !len_done)
        begin
            res.frame_status = ST_TRUNCATED;
        end
        else if (len_done && short_len)
        begin
            res.frame_status = ST_SHORT;
        end

        case (phase_reg)
            PH_HUNT:
            begin
                if (prev_byte_reg == HDR_FIRST && rx_byte == HDR_SECOND)
                begin
                    phase_next    = PH_CMD;
                    position_next = POS_W'(1);
                end
            end
            PH_CMD:
            begin
                frame_command_next = rx_byte;
                position_next      = POS_W'(2);
                phase_next         = PH_LEN;
            end
            PH_LEN:
            begin
                position_next = pos_inc;
                if (pos_inc == POS_W'(LEN_DONE_POS))
                begin
                    frame_length_next = {prev_byte_reg, rx_byte};
                    phase_next        = PH_DATA;
                end
            end
            PH_DATA:
            begin
                position_next = pos_inc;
                res_valid     = 1'b1;
                if (frame_end)
                begin
                    prev_byte_next = 8'd0;
                    phase_next     = PH_HUNT;
                end
            end
            default:
            begin
                phase_next     = PH_HUNT;
                prev_byte_next = 8'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HUNT;
            prev_byte_reg     <= 8'd0;
            position_reg      <= '0;
            frame_length_reg  <= '0;
            frame_command_reg <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg         <= phase_next;
            prev_byte_reg     <= prev_byte_next;
            position_reg      <= position_next;
            frame_length_reg  <= frame_length_next;
            frame_command_reg <= frame_command_next;
        end
    end

endmodule

// ===== hw/rtl/hlfd_out_stage.sv =====
// Output register that holds one result transaction until the downstream side takes it.
module hlfd_out_stage
    import hlfd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  logic    load_valid,
    input  result_t load_res,
    input  logic    out_ready,
    output logic    can_load,
    output logic    out_valid,
    output result_t out_res
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (out_ready)
        begin
            valid_next = 1'b0;
        end
        if (load && load_valid)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && load_valid)
        begin
            res_reg <= load_res;
        end
    end

endmodule

// ===== hw/rtl/header_length_frame_deframer_core.sv =====
// Top level of the header-length frame deframer: parser followed by a result register.
//
// Channel   Direction  Handshake           Payload
// input     in         valid / ready       rx_byte
// output    out        out_valid / out_ready  command, data_byte, byte_index,
//                                          is_checksum, last, frame_status
//
// One input transaction is accepted per cycle while ready is high; its result, if any,
// appears in the output register on the next cycle.
// The parser state and the result register both sit directly after the input port.
// Reset clears the hunt state and the output valid flag.
// Input stalls only while the output register holds a result that is not taken.
module header_length_frame_deframer_core
    import hlfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       valid,
    output logic       ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] command,
    output logic [7:0] data_byte,
    output logic [6:0] byte_index,
    output logic       is_checksum,
    output logic       last,
    output logic [1:0] frame_status
);

    logic    accept;
    logic    can_load;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign ready  = can_load;
    assign accept = valid && can_load;

    hlfd_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    hlfd_out_stage u_out_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .load_valid (res_valid),
        .load_res   (res),
        .out_ready  (out_ready),
        .can_load   (can_load),
        .out_valid  (out_valid),
        .out_res    (out_res)
    );

    assign command      = out_res.command;
    assign data_byte    = out_res.data_byte;
    assign byte_index   = out_res.byte_index;
    assign is_checksum  = out_res.is_checksum;
    assign last         = out_res.last;
    assign frame_status = out_res.frame_status;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the header-length frame deframer core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hlfd_pkg::*;

    localparam int ITEM_TARGET    = 700;
    localparam int HOLD_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int DATA_BYTES_MAX = MAX_POSITION - DATA_FIRST_POS + 2;

    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        logic [7:0] cmd;
        logic [7:0] data;
        logic [6:0] idx;
        logic       chk;
        logic       lst;
        logic [1:0] st;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] command;
    logic [7:0] data_byte;
    logic [6:0] byte_index;
    logic       is_checksum;
    logic       last;
    logic [1:0] frame_status;

    stim_row_t directed_rows [0:20] = '{
        '{8'h7F, 1'b0, 8'h00, 8'h00, 7'd0, 1'b0, 1'b0, ST_COMPLETE},
        '{8'hFA, 1'b0, 8'h00, 8'h00, 7'd0, 1'b0, 1'b0, ST_COMPLETE},
        '{8'hFA, 1'b0, 8'h00, 8'h00, 7'd0, 1'b0, 1'b0, ST_COMPLETE},
        '{8'hFB, 1'b0, 8'h00, 8'h00, 7'd0, 1'b0, 1'b0, ST_COMPLETE},
        '{8'hFA, 1'b0, 8'h00, 8'h00, 7'd0, 1'b0, 1'b0, ST_COMPLETE},
        '{8'h00, 1'b0, 8'h00, 8'h00, 7'd0, 1'b0, 1'b0, ST_COMPLETE},
        '{8'h00, 1'b0, 8'h00, 8'h00, 7'd0, 1'b0, 1'b0, ST_COMPLETE},
        '{8'hD1, 1'b1, 8'hFA, 8'hD1, 7'd0, 1'b0, 1'b1, ST_SHORT},
        '{8'hFA, 1'b0, 8'h00, 8'h00, 7'd0, 1'b0, 1'b0, ST_COMPLETE},
        '{8'hFB, 1'b0, 8'h00, 8'h00, 7'd0, 1'b0, 1'b0, ST_COMPLETE},
        '{8'h12, 1'b0, 8'h00, 8'h00, 7'd0, 1'b0, 1'b0, ST_COMPLETE},
        '{8'h00, 1'b0, 8'h00, 8'h00, 7'd0, 1'b0, 1'b0, ST_COMPLETE},
        '{8'h01, 1'b0, 8'h00, 8'h00, 7'd0, 1'b0, 1'b0, ST_COMPLETE},
        '{8'hFF, 1'b1, 8'h12, 8'hFF, 7'd0, 1'b1, 1'b1, ST_SHORT},
        '{8'hFA, 1'b0, 8'h00, 8'h00, 7'd0, 1'b0, 1'b0, ST_COMPLETE},
        '{8'hFB, 1'b0, 8'h00, 8'h00, 7'd0, 1'b0, 1'b0, ST_COMPLETE},
        '{8'h00, 1'b0, 8'h00, 8'h00, 7'd0, 1'b0, 1'b0, ST_COMPLETE},
        '{8'h00, 1'b0, 8'h00, 8'h00, 7'd0, 1'b0, 1'b0, ST_COMPLETE},
        '{8'h02, 1'b0, 8'h00, 8'h00, 7'd0, 1'b0, 1'b0, ST_COMPLETE},
        '{8'hAA, 1'b1, 8'h00, 8'hAA, 7'd0, 1'b1, 1'b0, ST_COMPLETE},
        '{8'h55, 1'b1, 8'h00, 8'h55, 7'd1, 1'b1, 1'b1, ST_COMPLETE}
    };

    stim_row_t   byte_stream [$];
    result_t     pending_results [$];
    int unsigned bytes_taken = 0;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_request = 1'b0;

    logic [7:0]  hist_prev = 8'h00;
    logic [7:0]  hist_last = 8'h00;
    phase_t      parse_phase = PH_HUNT;
    int unsigned parse_pos = 0;
    logic [15:0] frame_len = 16'h0000;
    logic [7:0]  frame_cmd = 8'h00;

    header_length_frame_deframer_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .valid        (valid),
        .ready        (ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .command      (command),
        .data_byte    (data_byte),
        .byte_index   (byte_index),
        .is_checksum  (is_checksum),
        .last         (last),
        .frame_status (frame_status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit deframe_byte(input logic [7:0] b, output result_t res);
        int unsigned len;
        bit          len_done;
        bit          past_limit;
        bit          counted;
        res = '0;
        hist_prev = hist_last;
        hist_last = b;
        case (parse_phase)
            PH_HUNT:
            begin
                if (hist_prev == HDR_FIRST && hist_last == HDR_SECOND)
                begin
                    parse_phase = PH_CMD;
                    parse_pos = 1;
                end
                return 1'b0;
            end
            PH_CMD:
            begin
                frame_cmd = b;
                parse_pos = 2;
                parse_phase = PH_LEN;
                return 1'b0;
            end
            PH_LEN:
            begin
                parse_pos++;
                if (parse_pos == LEN_DONE_POS)
                begin
                    frame_len = {hist_prev, hist_last};
                    parse_phase = PH_DATA;
                end
                return 1'b0;
            end
            default:
            begin
            end
        endcase
        parse_pos++;
        len = frame_len;
        len_done = parse_pos > len + LEN_OVERHEAD;
        past_limit = parse_pos > MAX_POSITION;
        counted = parse_pos <= len + LEN_OVERHEAD + 1;
        res.command = frame_cmd;
        res.data_byte = b;
        res.byte_index = 7'(parse_pos - DATA_FIRST_POS);
        res.is_checksum = counted && (parse_pos >= len + LEN_OVERHEAD);
        res.last = len_done || past_limit;
        if (len_done)
            res.frame_status = (len < SHORT_LEN) ? ST_SHORT : ST_COMPLETE;
        else if (past_limit)
            res.frame_status = ST_TRUNCATED;
        else
            res.frame_status = ST_COMPLETE;
        if (res.last)
        begin
            hist_prev = 8'h00;
            hist_last = 8'h00;
            parse_phase = PH_HUNT;
        end
        return 1'b1;
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        stim_row_t row;
        row = '0;
        row.rx = b;
        byte_stream.push_back(row);
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 3))
            0: return HDR_FIRST;
            1: return HDR_SECOND;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly well-formed frames with random content, mixed with noise and cut-off frames.
    function automatic void build_random_frames(input int unsigned target);
        int unsigned kind;
        int unsigned pick;
        int unsigned len;
        int unsigned data_count;
        while (byte_stream.size() < target)
        begin
            kind = $urandom_range(0, 99);
            repeat ($urandom_range(0, 2)) add_byte(noise_byte());
            if (kind < 8)
                continue;
            add_byte(HDR_FIRST);
            add_byte(HDR_SECOND);
            add_byte(8'($urandom_range(0, 255)));
            pick = $urandom_range(0, 99);
            if (pick < 5)
                len = $urandom_range(122, 126);
            else if (pick < 9)
                len = $urandom_range(127, 65535);
            else
                len = $urandom_range(0, 10);
            add_byte(len[15:8]);
            add_byte(len[7:0]);
            data_count = (len == 0) ? 1 : len;
            if (data_count > DATA_BYTES_MAX - 1)
                data_count = DATA_BYTES_MAX - 1;
            if (kind < 18)
                data_count = $urandom_range(0, data_count - 1);
            repeat (data_count) add_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : input_monitor
        result_t   predicted;
        bit        has_result;
        stim_row_t row;
        if (rst_n && valid && ready)
        begin
            has_result = deframe_byte(rx_byte, predicted);
            row = byte_stream[bytes_taken];
            if (row.typed)
                pending_results.push_back('{row.cmd, row.data, row.idx, row.chk, row.lst,
                                            status_t'(row.st)});
            else if (has_result)
                pending_results.push_back(predicted);
            bytes_taken++;
        end
    end

    always @(posedge clk)
    begin : result_checker
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with none expected, data_byte %0h", $realtime, data_byte);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("command", want.command, command);
                compare_field("data_byte", want.data_byte, data_byte);
                compare_field("byte_index", want.byte_index, byte_index);
                compare_field("is_checksum", want.is_checksum, is_checksum);
                compare_field("last", want.last, last);
                compare_field("frame_status", want.frame_status, frame_status);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((valid && ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(1, 100) > recv_stall_pct);
        end
    end

    initial
    begin : sender
        int unsigned rand_start;
        int unsigned rand_count;
        int unsigned segment;
        rst_n = 1'b0;
        valid <= 1'b0;
        rx_byte <= 8'h00;
        foreach (directed_rows[k])
            byte_stream.push_back(directed_rows[k]);
        rand_start = byte_stream.size();
        build_random_frames(rand_start + ITEM_TARGET);
        rand_count = byte_stream.size() - rand_start;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int unsigned i = 0; i < byte_stream.size(); i++)
        begin
            if (i >= rand_start)
            begin
                segment = (i - rand_start) * 4 / rand_count;
                send_idle_pct = (segment == 1) ? 77 : (segment == 3) ? 11 : 0;
                recv_stall_pct = (segment == 2) ? 77 : (segment == 3) ? 11 : 0;
                if (i == rand_start + rand_count / 8)
                    hold_request = 1'b1;
            end
            while ($urandom_range(1, 100) <= send_idle_pct)
            begin
                valid <= 1'b0;
                @(posedge clk);
            end
            valid <= 1'b1;
            rx_byte <= byte_stream[i].rx;
            @(posedge clk);
            while (!ready)
                @(posedge clk);
        end
        valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/hlfd_pkg.sv
hw/rtl/hlfd_parser.sv
hw/rtl/hlfd_out_stage.sv
hw/rtl/header_length_frame_deframer_core.sv
tb/sv/testbench.sv
